>>> rtl/tse_pkg.sv
package tse_pkg;

  // parser phases
  localparam logic [3:0] PH_HEADER   = 4'd0;
  localparam logic [3:0] PH_RANDOM   = 4'd1;
  localparam logic [3:0] PH_SID_LEN  = 4'd2;
  localparam logic [3:0] PH_SKIP_SID = 4'd3;
  localparam logic [3:0] PH_CS_HI    = 4'd4;
  localparam logic [3:0] PH_CS_LO    = 4'd5;
  localparam logic [3:0] PH_SKIP_CS  = 4'd6;
  localparam logic [3:0] PH_CM_LEN   = 4'd7;
  localparam logic [3:0] PH_SKIP_CM  = 4'd8;
  localparam logic [3:0] PH_EXTS_HI  = 4'd9;
  localparam logic [3:0] PH_EXTS_LO  = 4'd10;
  localparam logic [3:0] PH_EXT_HDR  = 4'd11;
  localparam logic [3:0] PH_SNI_HDR  = 4'd12;
  localparam logic [3:0] PH_NAME     = 4'd13;
  localparam logic [3:0] PH_SKIP_EXT = 4'd14;
  localparam logic [3:0] PH_DONE     = 4'd15;

  // internal packet outcome
  localparam logic [2:0] OC_PENDING   = 3'd0;
  localparam logic [2:0] OC_NOT_CH    = 3'd1;
  localparam logic [2:0] OC_FOUND     = 3'd2;
  localparam logic [2:0] OC_NOT_FOUND = 3'd3;
  localparam logic [2:0] OC_LONG      = 3'd5;

  // reported status
  localparam logic [2:0] ST_NOT_CH     = 3'd0;
  localparam logic [2:0] ST_FOUND      = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
  localparam logic [2:0] ST_TRUNCATED  = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;

  localparam logic KIND_NAME   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // header bytes and their positions
  localparam logic [7:0] REC_HANDSHAKE = 8'h16;
  localparam logic [7:0] VER_MAJOR     = 8'h03;
  localparam logic [7:0] VER_MINOR     = 8'h03;
  localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
  localparam logic [7:0] LEN_TOP_ZERO  = 8'h00;
  localparam logic [7:0] NAME_TYPE_HOST = 8'h00;

  localparam int HP_TYPE     = 0;
  localparam int HP_VER_MAJ  = 1;
  localparam int HP_RLEN_HI  = 3;
  localparam int HP_RLEN_LO  = 4;
  localparam int HP_HS_TYPE  = 5;
  localparam int HP_HLEN_TOP = 6;
  localparam int HP_HLEN_HI  = 7;
  localparam int HP_HLEN_LO  = 8;
  localparam int HP_CV_MAJ   = 9;
  localparam int HP_CV_MIN   = 10;

  localparam int RANDOM_END  = 43;
  localparam int HDR_BYTES   = 11;
  localparam logic [15:0] RANDOM_SKIP = 16'(RANDOM_END - HDR_BYTES);
  localparam logic [15:0] HS_HDR_LEN  = 16'd4;

  typedef struct packed {
    logic       kind;
    logic [7:0] name_byte;
    logic [2:0] status;
    logic       run_last;
  } res_t;

  typedef struct packed {
    logic name_vld;
    logic stat_vld;
    res_t name_res;
    res_t stat_res;
  } push_t;

endpackage

>>> rtl/tse_in_if.sv
interface tse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       last_byte;

  modport source (output valid, payload_byte, last_byte, input ready);
  modport sink (input valid, payload_byte, last_byte, output ready);
endinterface

>>> rtl/tse_out_if.sv
interface tse_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] name_byte;
  logic [2:0] status;
  logic       run_last;

  modport source (output valid, kind, name_byte, status, run_last, input ready);
  modport sink (input valid, kind, name_byte, status, run_last, output ready);
endinterface

>>> rtl/tse_parser.sv
module tse_parser #(
  parameter int MAX_NAME      = 255,
  parameter int POSITION_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    b,
  input  logic          last,
  output tse_pkg::push_t push
);
  import tse_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam int EW = ((PB > 16) ? PB : 16) + 1;
  localparam int NW = $clog2(MAX_NAME + 1);

  logic [PB-1:0] pos, pos_next;
  logic [3:0]    phase, phase_next;
  logic [15:0]   rec_len, rec_len_next;
  logic [15:0]   hs_len, hs_len_next;
  logic [15:0]   cnt, cnt_next;
  logic [EW-1:0] exts_end, exts_end_next;
  logic [15:0]   ext_type, ext_type_next;
  logic [EW-1:0] ext_end, ext_end_next;
  logic [15:0]   name_rem, name_rem_next;
  logic [NW-1:0] name_cnt, name_cnt_next;
  logic [2:0]    outcome, outcome_next;

  logic [EW-1:0] qn;
  logic [EW-1:0] ext_end_sum;
  logic [15:0]   cnt_dec;
  logic [15:0]   rem_dec;
  logic          have_name;
  logic [2:0]    st;

  assign qn          = EW'(pos) + EW'(1);
  assign ext_end_sum = qn + EW'({ext_end[15:8], b});
  assign cnt_dec     = (cnt != 16'd0) ? cnt - 16'd1 : cnt;
  assign rem_dec     = (name_rem != 16'd0) ? name_rem - 16'd1 : name_rem;

  always_comb begin
    pos_next      = pos;
    phase_next    = phase;
    rec_len_next  = rec_len;
    hs_len_next   = hs_len;
    cnt_next      = cnt;
    exts_end_next = exts_end;
    ext_type_next = ext_type;
    ext_end_next  = ext_end;
    name_rem_next = name_rem;
    name_cnt_next = name_cnt;
    outcome_next  = outcome;
    have_name     = 1'b0;
    st            = ST_NOT_FOUND;

    case (phase)
      PH_HEADER: begin
        if (pos == PB'(HP_TYPE)) begin
          if (b != REC_HANDSHAKE) begin
            phase_next = PH_DONE; outcome_next = OC_NOT_CH;
          end
        end else if (pos == PB'(HP_VER_MAJ)) begin
          if (b != VER_MAJOR) begin
            phase_next = PH_DONE; outcome_next = OC_NOT_CH;
          end
        end else if (pos == PB'(HP_RLEN_HI)) begin
          rec_len_next = {b, 8'h00};
        end else if (pos == PB'(HP_RLEN_LO)) begin
          rec_len_next = {rec_len[15:8], b};
        end else if (pos == PB'(HP_HS_TYPE)) begin
          if (b != HS_CLIENT_HELLO) begin
            phase_next = PH_DONE; outcome_next = OC_NOT_CH;
          end
        end else if (pos == PB'(HP_HLEN_TOP)) begin
          if (b != LEN_TOP_ZERO) begin
            phase_next = PH_DONE; outcome_next = OC_NOT_CH;
          end
        end else if (pos == PB'(HP_HLEN_HI)) begin
          hs_len_next = {b, 8'h00};
        end else if (pos == PB'(HP_HLEN_LO)) begin
          hs_len_next = {hs_len[15:8], b};
          // record length must equal the handshake length plus its header, compared without wrap
          if ({1'b0, rec_len} != {1'b0, hs_len[15:8], b} + {1'b0, HS_HDR_LEN}) begin
            phase_next = PH_DONE; outcome_next = OC_NOT_CH;
          end
        end else if (pos == PB'(HP_CV_MAJ)) begin
          if (b != VER_MAJOR) begin
            phase_next = PH_DONE; outcome_next = OC_NOT_FOUND;
          end
        end else if (pos == PB'(HP_CV_MIN)) begin
          if (b != VER_MINOR) begin
            phase_next = PH_DONE; outcome_next = OC_NOT_FOUND;
          end else begin
            cnt_next   = RANDOM_SKIP;
            phase_next = PH_RANDOM;
          end
        end
      end
      PH_RANDOM, PH_SKIP_SID, PH_SKIP_CS, PH_SKIP_CM: begin
        cnt_next = cnt_dec;
        if (cnt_dec == 16'd0) begin
          case (phase)
            PH_RANDOM:   phase_next = PH_SID_LEN;
            PH_SKIP_SID: phase_next = PH_CS_HI;
            PH_SKIP_CS:  phase_next = PH_CM_LEN;
            default:     phase_next = PH_EXTS_HI;
          endcase
        end
      end
      PH_SID_LEN: begin
        cnt_next   = {8'h00, b};
        phase_next = (b != 8'h00) ? PH_SKIP_SID : PH_CS_HI;
      end
      PH_CS_HI: begin
        cnt_next   = {b, 8'h00};
        phase_next = PH_CS_LO;
      end
      PH_CS_LO: begin
        cnt_next   = {cnt[15:8], b};
        phase_next = ({cnt[15:8], b} != 16'd0) ? PH_SKIP_CS : PH_CM_LEN;
      end
      PH_CM_LEN: begin
        cnt_next   = {8'h00, b};
        phase_next = (b != 8'h00) ? PH_SKIP_CM : PH_EXTS_HI;
      end
      PH_EXTS_HI: begin
        cnt_next   = {b, 8'h00};
        phase_next = PH_EXTS_LO;
      end
      PH_EXTS_LO: begin
        exts_end_next = qn + EW'({cnt[15:8], b});
        if (qn >= qn + EW'({cnt[15:8], b})) begin
          phase_next = PH_DONE; outcome_next = OC_NOT_FOUND;
        end else begin
          phase_next = PH_EXT_HDR; cnt_next = 16'd0;
        end
      end
      PH_EXT_HDR: begin
        case (cnt)
          16'd0: begin ext_type_next = {b, 8'h00}; cnt_next = 16'd1; end
          16'd1: begin ext_type_next = {ext_type[15:8], b}; cnt_next = 16'd2; end
          16'd2: begin ext_end_next = EW'({b, 8'h00}); cnt_next = 16'd3; end
          default: begin
            ext_end_next = ext_end_sum;
            if (ext_type == 16'd0) begin
              phase_next = PH_SNI_HDR; cnt_next = 16'd0;
            end else if (ext_end_sum <= qn) begin
              // empty extension: next header starts right here
              if (qn >= exts_end) begin
                phase_next = PH_DONE; outcome_next = OC_NOT_FOUND;
              end else begin
                phase_next = PH_EXT_HDR; cnt_next = 16'd0;
              end
            end else begin
              phase_next = PH_SKIP_EXT;
            end
          end
        endcase
      end
      PH_SNI_HDR: begin
        case (cnt)
          16'd0, 16'd1: cnt_next = cnt + 16'd1;
          16'd2: begin
            if (b != NAME_TYPE_HOST) begin
              phase_next = PH_DONE; outcome_next = OC_NOT_FOUND;
            end else begin
              cnt_next = 16'd3;
            end
          end
          16'd3: begin name_rem_next = {b, 8'h00}; cnt_next = 16'd4; end
          default: begin
            name_rem_next = {name_rem[15:8], b};
            name_cnt_next = '0;
            if ({name_rem[15:8], b} == 16'd0) begin
              phase_next = PH_DONE; outcome_next = OC_FOUND;
            end else begin
              phase_next = PH_NAME;
            end
          end
        endcase
      end
      PH_NAME: begin
        if (name_cnt < NW'(MAX_NAME)) begin
          have_name     = 1'b1;
          name_cnt_next = name_cnt + NW'(1);
        end else begin
          outcome_next = OC_LONG;
        end
        name_rem_next = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_next = PH_DONE;
          outcome_next = (outcome_next == OC_LONG) ? OC_LONG : OC_FOUND;
        end
      end
      PH_SKIP_EXT: begin
        if (qn >= ext_end) begin
          if (qn >= exts_end) begin
            phase_next = PH_DONE; outcome_next = OC_NOT_FOUND;
          end else begin
            phase_next = PH_EXT_HDR; cnt_next = 16'd0;
          end
        end
      end
      default: ;
    endcase

    // status reported on the final byte
    if (phase_next == PH_DONE) begin
      if (outcome_next == OC_NOT_CH) begin
        st = ST_NOT_CH;
      end else if (outcome_next == OC_FOUND || outcome_next == OC_LONG) begin
        if (exts_end_next > qn) st = ST_NOT_FOUND;
        else if (outcome_next == OC_LONG) st = ST_TOO_LONG;
        else st = ST_FOUND;
      end else begin
        st = ST_NOT_FOUND;
      end
    end else if (phase_next == PH_HEADER) begin
      st = ST_NOT_CH;
    end else if (phase_next == PH_NAME) begin
      st = ST_TRUNCATED;
    end else begin
      st = ST_NOT_FOUND;
    end

    if (!last) begin
      if (pos != '1) begin
        pos_next = pos + PB'(1);
      end else if (phase_next != PH_DONE) begin
        // counter full: give up on a parse still running
        phase_next = PH_DONE; outcome_next = OC_NOT_FOUND;
      end
    end
  end

  always_comb begin
    push.name_vld           = step && have_name;
    push.stat_vld           = step && last;
    push.name_res.kind      = KIND_NAME;
    push.name_res.name_byte = b;
    push.name_res.status    = ST_NOT_CH;
    push.name_res.run_last  = !last;
    push.stat_res.kind      = KIND_STATUS;
    push.stat_res.name_byte = 8'h00;
    push.stat_res.status    = st;
    push.stat_res.run_last  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last)) begin
      pos      <= '0;
      phase    <= PH_HEADER;
      rec_len  <= '0;
      hs_len   <= '0;
      cnt      <= '0;
      exts_end <= '0;
      ext_type <= '0;
      ext_end  <= '0;
      name_rem <= '0;
      name_cnt <= '0;
      outcome  <= OC_PENDING;
    end else if (step) begin
      pos      <= pos_next;
      phase    <= phase_next;
      rec_len  <= rec_len_next;
      hs_len   <= hs_len_next;
      cnt      <= cnt_next;
      exts_end <= exts_end_next;
      ext_type <= ext_type_next;
      ext_end  <= ext_end_next;
      name_rem <= name_rem_next;
      name_cnt <= name_cnt_next;
      outcome  <= outcome_next;
    end
  end

  a_done_has_outcome: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> outcome != OC_PENDING)
    else $error("parser finished without an outcome");

  a_name_only_in_name_phase: assert property (@(posedge clk) disable iff (rst)
    push.name_vld |-> phase == PH_NAME && name_cnt < NW'(MAX_NAME))
    else $error("name byte sent outside the name");

  a_reset_after_last: assert property (@(posedge clk) disable iff (rst)
    step && last |=> pos == '0 && phase == PH_HEADER)
    else $error("parser not cleared after final byte");

endmodule

>>> rtl/tse_result_fifo.sv
module tse_result_fifo (
  input  logic           clk,
  input  logic           rst,
  input  tse_pkg::push_t push,
  output logic           room,
  tse_out_if.source      res
);
  import tse_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  res_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;
  logic          pop;
  logic [AW:0]   n_push;
  res_t          head;

  assign pop    = res.valid && res.ready;
  assign n_push = (AW+1)'(push.name_vld) + (AW+1)'(push.stat_vld);
  // two free slots so one input item can always land
  assign room   = count <= (AW+1)'(DEPTH - 2);
  assign head   = mem[rp];

  assign res.valid     = count != '0;
  assign res.kind      = head.kind;
  assign res.name_byte = head.name_byte;
  assign res.status    = head.status;
  assign res.run_last  = head.run_last;

  always_ff @(posedge clk) begin
    if (push.name_vld) mem[wp] <= push.name_res;
    if (push.stat_vld) mem[wp + AW'(push.name_vld)] <= push.stat_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + n_push[AW-1:0];
      if (pop) rp <= rp + AW'(1);
      count <= count + n_push - (AW+1)'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count + n_push <= (AW+1)'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    n_push != '0 |-> room)
    else $error("item taken without queue room");

  a_pop_only_count: assert property (@(posedge clk) disable iff (rst)
    pop && n_push == '0 |=> count == $past(count) - (AW+1)'(1))
    else $error("queue count out of step");

endmodule

>>> rtl/tls_sni_extractor.sv
// TLS client hello server-name extractor. Feed one TCP payload byte per item with last_byte
// set on the final byte; the block returns up to MAX_NAME host name bytes as kind 0
// items while they stream past, and one kind 1 status item after the final byte (name bytes
// count only when that status is found). It takes one byte every cycle while the result
// queue has room: a byte goes through an input register, the combinational parse logic and
// a four-entry result queue. A final byte that also carries a name byte gives two results,
// and the input holds off only while the result queue lacks room for two.
module tls_sni_extractor #(
  parameter int MAX_NAME      = 255,
  parameter int POSITION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  tse_in_if.sink    pkt,
  tse_out_if.source res
);
  import tse_pkg::*;

  logic       vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       room;
  logic       adv;
  push_t      push;

  assign adv       = vld_q && room;
  assign pkt.ready = !vld_q || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (pkt.valid && pkt.ready) begin
      vld_q <= 1'b1;
    end else if (adv) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.valid && pkt.ready) begin
      byte_q <= pkt.payload_byte;
      last_q <= pkt.last_byte;
    end
  end

  tse_parser #(
    .MAX_NAME      (MAX_NAME),
    .POSITION_BITS (POSITION_BITS)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .step (adv),
    .b    (byte_q),
    .last (last_q),
    .push (push)
  );

  tse_result_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (res)
  );

endmodule
